// ===== rtl/bloom_filter_double_hash_macros.svh =====
// ----------------------------------------------------------------------------
// Bloom filter assertion macros
// Shared assertion helpers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_DOUBLE_HASH_MACROS_SVH
`define BLOOM_FILTER_DOUBLE_HASH_MACROS_SVH
`ifndef ASSERT_OFF
`define BFDH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BFDH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define BFDH_ASSERT(lbl, prop, msg)
`define BFDH_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/bfdh_pkg.sv =====
// ----------------------------------------------------------------------------
// bfdh_pkg
// Request codes, hash constants and the hash request type.
// ----------------------------------------------------------------------------
package bfdh_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [63:0] LEN_MUL  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_A    = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_B    = 64'h4cf5ad432745937f;
  localparam logic [63:0] STEP_ADD = 64'h0000000052dce729;
  localparam logic [63:0] SEED_ONE = 64'h5a4f9a3b1c6d8e2f;
  localparam logic [63:0] SEED_TWO = 64'hc8d3e1f4a5b6c7d8;

  typedef struct packed {
    logic [63:0] word;
    logic [15:0] len;
    logic        last;
    logic        new_key;
  } hash_req_t;

endpackage

// ===== rtl/bfdh_mul64.sv =====
// ----------------------------------------------------------------------------
// bfdh_mul64
// 64x64 multiply, low 64 bits, from three 32x32 partial products.
// ----------------------------------------------------------------------------
module bfdh_mul64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  logic [63:0] a_q, b_q, acc_q;
  logic [1:0]  step_q;
  logic        busy_q, done_q;
  logic [31:0] op_x, op_y;
  logic [63:0] prod;

  assign op_x = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
  assign op_y = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];
  assign prod = 64'(op_x) * 64'(op_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      if (step_q == 2'd0) begin
        acc_q <= prod;
      end else begin
        acc_q <= acc_q + {prod[31:0], 32'h0};
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ===== rtl/bfdh_mod.sv =====
// ----------------------------------------------------------------------------
// bfdh_mod
// Restoring remainder of a 64-bit value by the filter size, one bit a cycle.
// ----------------------------------------------------------------------------
module bfdh_mod #(
  parameter int unsigned MW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   num_i,
  input  logic [MW-1:0] den_i,
  output logic          done_o,
  output logic [MW-1:0] rem_o
);

  logic [63:0]   num_q;
  logic [MW-1:0] den_q, rem_q;
  logic [5:0]    cnt_q;
  logic          busy_q, done_q;
  logic [MW:0]   trial, diff;

  assign trial = {rem_q, num_q[63]};
  assign diff  = (trial >= {1'b0, den_q}) ? trial - {1'b0, den_q} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[62:0], 1'b0};
      rem_q <= diff[MW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/bfdh_hash.sv =====
// ----------------------------------------------------------------------------
// bfdh_hash
// Sequencer for the two key hashes; all multiplies share one bfdh_mul64.
// ----------------------------------------------------------------------------
module bfdh_hash import bfdh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  hash_req_t   req_i,
  output logic        done_o,
  output logic [63:0] h1_o,
  output logic [63:0] h2_o
);

  typedef enum logic [2:0] {
    H_IDLE, H_INIT, H_PRE, H_SCR1, H_SCR2, H_FSTART, H_FIN1, H_FIN2
  } hstate_e;

  hstate_e     state_q;
  hash_req_t   req_q;
  logic [63:0] h1_q, h2_q;
  logic        done_q;
  logic        mul_start_q;
  logic [63:0] mul_a_q, mul_b_q;
  logic        mul_done;
  logic [63:0] mul_p;
  logic        is_tail, is_skip;
  logic [63:0] key_val, scr_val;

  function automatic logic [63:0] absorb(input logic [63:0] h, input logic [63:0] s);
    logic [63:0] r, rot;
    r   = h ^ s;
    rot = {r[36:0], r[63:37]};
    return (rot << 2) + rot + STEP_ADD;
  endfunction

  function automatic logic [63:0] pre_fin(input logic [63:0] h);
    return h ^ (h >> 37);
  endfunction

  assign is_tail = req_q.last && (req_q.len[2:0] != 3'd0);
  assign is_skip = req_q.last && (req_q.len == 16'd0);
  assign key_val = is_tail ? (req_q.word & ~({64{1'b1}} << {req_q.len[2:0], 3'b000}))
                           : req_q.word;
  assign scr_val = mul_p ^ (mul_p >> 31);

  bfdh_mul64 u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= H_IDLE;
      done_q      <= 1'b0;
      mul_start_q <= 1'b0;
      h1_q        <= '0;
      h2_q        <= '0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      req_q       <= '0;
    end else begin
      done_q      <= 1'b0;
      mul_start_q <= 1'b0;
      unique case (state_q)
        H_IDLE: begin
          if (start_i) begin
            req_q <= req_i;
            if (req_i.new_key) begin
              mul_start_q <= 1'b1;
              mul_a_q     <= {48'h0, req_i.len};
              mul_b_q     <= LEN_MUL;
              state_q     <= H_INIT;
            end else begin
              state_q <= H_PRE;
            end
          end
        end
        H_INIT: begin
          if (mul_done) begin
            h1_q    <= SEED_ONE ^ mul_p;
            h2_q    <= SEED_TWO ^ mul_p;
            state_q <= H_PRE;
          end
        end
        H_PRE: begin
          if (is_skip) begin
            state_q <= H_FSTART;
          end else begin
            mul_start_q <= 1'b1;
            mul_a_q     <= key_val;
            mul_b_q     <= MIX_A;
            state_q     <= H_SCR1;
          end
        end
        H_SCR1: begin
          if (mul_done) begin
            mul_start_q <= 1'b1;
            mul_a_q     <= scr_val;
            mul_b_q     <= MIX_B;
            state_q     <= H_SCR2;
          end
        end
        H_SCR2: begin
          if (mul_done) begin
            if (is_tail) begin
              h1_q <= h1_q ^ mul_p;
              h2_q <= h2_q ^ mul_p;
            end else begin
              h1_q <= absorb(h1_q, mul_p);
              h2_q <= absorb(h2_q, mul_p);
            end
            state_q <= H_FSTART;
          end
        end
        H_FSTART: begin
          if (req_q.last) begin
            mul_start_q <= 1'b1;
            mul_a_q     <= pre_fin(h1_q);
            mul_b_q     <= STEP_ADD;
            state_q     <= H_FIN1;
          end else begin
            done_q  <= 1'b1;
            state_q <= H_IDLE;
          end
        end
        H_FIN1: begin
          if (mul_done) begin
            h1_q        <= mul_p ^ (mul_p >> 32);
            mul_start_q <= 1'b1;
            mul_a_q     <= pre_fin(h2_q);
            mul_b_q     <= STEP_ADD;
            state_q     <= H_FIN2;
          end
        end
        H_FIN2: begin
          if (mul_done) begin
            h2_q    <= mul_p ^ (mul_p >> 32);
            done_q  <= 1'b1;
            state_q <= H_IDLE;
          end
        end
        default: state_q <= H_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign h1_o   = h1_q;
  assign h2_o   = h2_q;

endmodule

// ===== rtl/bloom_filter_double_hash.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_double_hash
// Bloom filter over 64-bit key words with two murmur-style hashes.
// ----------------------------------------------------------------------------
// One request is handled at a time. A key word runs a chain of 64-bit
// multiplies, one more when it opens a key, on one shared 32x32
// multiplier (each multiply: a start, three partial products and a
// hand-back). A last word adds two finishing multiplies and then, per
// probe, a bit-serial modulo by the filter size, a read of the bit store
// and, for an insert, a write back. A query stops at the first clear bit.
// A clear request, and the sweep after reset, write MAX_BITS/64 store
// words, one per cycle; no request is taken during the sweep, while
// register writes are. A finished result waits in the output register
// while the next request is taken.
module bloom_filter_double_hash import bfdh_pkg::*; #(
  parameter int unsigned MAX_BITS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // key_word[63:0], key_len[79:64]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // maybe_present[0], zeros above
  output logic [1:0]  m_axis_tuser,   // completed_op[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "bloom_filter_double_hash_macros.svh"

  localparam int unsigned STORE_WORDS = MAX_BITS / 64;
  localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned MW = $clog2(MAX_BITS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_HASH, ST_PSTART, ST_MOD, ST_RD, ST_DONE
  } state_e;

  state_e        state_q;
  logic [16:0]   filter_bits_q;
  logic [7:0]    hash_count_q;
  logic [AW-1:0] clr_addr_q;
  logic          clr_report_q, kip_q, last_q, present_q;
  logic [1:0]    op_q;
  logic [63:0]   acc_q;
  logic [7:0]    probe_q;
  logic [MW-1:0] m_q, m_d;
  logic          out_valid_q, out_present_q;
  logic [1:0]    out_op_q;

  logic [63:0]   mem [STORE_WORDS];
  logic [63:0]   rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata;

  logic          accept, hash_start, hash_done, mod_start, mod_done;
  hash_req_t     hash_req;
  logic [63:0]   h1, h2;
  logic [MW-1:0] pos;
  logic [63:0]   bit_mask;
  logic          bit_hit;
  logic [31:0]   fb_ext;
  logic          cfg_wr;
  logic          out_load;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {24'h0, hash_count_q} : {15'h0, filter_bits_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_bits_q <= 17'd65536;
      hash_count_q  <= 8'd7;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        hash_count_q <= pwdata[7:0];
      end else begin
        filter_bits_q <= pwdata[16:0];
      end
    end
  end

  assign fb_ext = {15'h0, filter_bits_q};
  always_comb begin
    if (fb_ext < 32'd64) begin
      m_d = MW'(64);
    end else if (fb_ext > MAX_BITS) begin
      m_d = MW'(MAX_BITS);
    end else begin
      m_d = MW'(fb_ext);
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign hash_start    = accept && ((s_axis_tuser == REQ_INSERT) ||
                                    (s_axis_tuser == REQ_QUERY));
  assign hash_req.word    = s_axis_tdata[63:0];
  assign hash_req.len     = s_axis_tdata[79:64];
  assign hash_req.last    = s_axis_tlast;
  assign hash_req.new_key = !kip_q;

  bfdh_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .req_i   (hash_req),
    .done_o  (hash_done),
    .h1_o    (h1),
    .h2_o    (h2)
  );

  assign mod_start = (state_q == ST_PSTART) && (probe_q != hash_count_q);

  bfdh_mod #(.MW(MW)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .num_i   (acc_q),
    .den_i   (m_q),
    .done_o  (mod_done),
    .rem_o   (pos)
  );

  assign bit_mask  = 64'h1 << pos[5:0];
  assign bit_hit   = (rd_q & bit_mask) != 64'h0;
  assign mem_re    = (state_q == ST_MOD) && mod_done;
  assign mem_raddr = pos[AW+5:6];
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = 64'h0;
    if (state_q == ST_CLR) begin
      mem_we = 1'b1;
    end else if (state_q == ST_RD && op_q == REQ_INSERT) begin
      mem_we    = 1'b1;
      mem_waddr = pos[AW+5:6];
      mem_wdata = rd_q | bit_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLR;
      clr_addr_q    <= '0;
      clr_report_q  <= 1'b0;
      kip_q         <= 1'b0;
      last_q        <= 1'b0;
      present_q     <= 1'b0;
      op_q          <= REQ_INSERT;
      acc_q         <= '0;
      probe_q       <= '0;
      m_q           <= '0;
      out_valid_q   <= 1'b0;
      out_present_q <= 1'b0;
      out_op_q      <= REQ_INSERT;
    end else begin
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == LAST_ADDR) begin
            state_q <= clr_report_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (s_axis_tuser) inside
              REQ_CLEAR: begin
                clr_addr_q   <= '0;
                clr_report_q <= 1'b1;
                kip_q        <= 1'b0;
                op_q         <= REQ_CLEAR;
                state_q      <= ST_CLR;
              end
              REQ_INSERT, REQ_QUERY: begin
                kip_q   <= !s_axis_tlast;
                last_q  <= s_axis_tlast;
                op_q    <= s_axis_tuser;
                state_q <= ST_HASH;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            if (last_q) begin
              acc_q     <= h1;
              probe_q   <= '0;
              present_q <= 1'b1;
              m_q       <= m_d;
              state_q   <= ST_PSTART;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_PSTART: begin
          state_q <= (probe_q == hash_count_q) ? ST_DONE : ST_MOD;
        end
        ST_MOD: begin
          if (mod_done) begin
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          if (op_q == REQ_QUERY && !bit_hit) begin
            present_q <= 1'b0;
            state_q   <= ST_DONE;
          end else begin
            acc_q   <= acc_q + h2;
            probe_q <= probe_q + 8'd1;
            state_q <= ST_PSTART;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_valid_q   <= 1'b1;
            out_op_q      <= op_q;
            out_present_q <= (op_q == REQ_QUERY) && present_q;
            clr_report_q  <= 1'b0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_op_q;
  assign m_axis_tdata  = {7'h0, out_present_q};

  `BFDH_ASSERT(a_no_accept_in_sweep, !(state_q == ST_CLR && s_axis_tready), "accept in sweep")
  `BFDH_ASSERT(a_hash_done_waited, !hash_done || state_q == ST_HASH, "stray hash done")
  `BFDH_ASSERT(a_mod_done_waited, !mod_done || state_q == ST_MOD, "stray modulo done")
  `BFDH_ASSERT_NEXT(a_done_to_idle, out_load, m_axis_tvalid && state_q == ST_IDLE, "result lost")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Bloom filter testbench
// Streams insert, query and clear requests into the filter under random
// sender bursts and receiver stalls. A scoreboard predicts every result from
// its own copy of the hashes, the bit store and the registers, and checks
// each completed operation in order.
// ----------------------------------------------------------------------------
module tb;
  import bfdh_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_FILTER_BITS = 3'd0;
  localparam logic [2:0] ADDR_HASH_COUNT  = 3'd4;
  localparam int STORE_WORDS = 1024;
  localparam int IDLE_PAUSE  = 2500;

  typedef struct packed {
    logic [1:0] op;
    logic       present;
  } bloom_result_t;

  class bloom_scoreboard;
    logic [63:0]   store [STORE_WORDS];
    logic [63:0]   acc_one, acc_two;
    bit            in_key;
    logic [16:0]   filter_bits;
    logic [7:0]    hash_count;
    bloom_result_t pending [$];
    int            errors;

    function new();
      foreach (store[i]) store[i] = '0;
      acc_one = '0; acc_two = '0; in_key = 0;
      filter_bits = 17'd65536; hash_count = 8'd7; errors = 0;
    endfunction

    function logic [63:0] scramble(logic [63:0] k);
      k = k * MIX_A;
      k = k ^ (k >> 31);
      return k * MIX_B;
    endfunction

    function logic [63:0] absorb(logic [63:0] h, logic [63:0] k);
      h = h ^ scramble(k);
      h = {h[36:0], h[63:37]};
      return h * 64'd5 + STEP_ADD;
    endfunction

    function logic [63:0] finalize(logic [63:0] h);
      h = h ^ (h >> 37);
      h = h * STEP_ADD;
      return h ^ (h >> 32);
    endfunction

    function void note(logic [1:0] req, logic [63:0] word, logic [15:0] len, bit last);
      logic [63:0] len64, k, f1, f2, m, pos, idx;
      bit present;
      int tail;
      if (req == REQ_UNUSED) return;
      if (req == REQ_CLEAR) begin
        foreach (store[i]) store[i] = '0;
        in_key = 0; acc_one = '0; acc_two = '0;
        pending.push_back('{REQ_CLEAR, 1'b0});
        return;
      end
      len64 = {48'd0, len};
      if (!in_key) begin
        acc_one = SEED_ONE ^ (len64 * LEN_MUL);
        acc_two = SEED_TWO ^ (len64 * LEN_MUL);
        in_key = 1;
      end
      tail = int'(len[2:0]);
      if (last && tail != 0) begin
        k = word & ((64'd1 << (8 * tail)) - 64'd1);
        acc_one = acc_one ^ scramble(k);
        acc_two = acc_two ^ scramble(k);
      end else if (!(last && len == 0)) begin
        acc_one = absorb(acc_one, word);
        acc_two = absorb(acc_two, word);
      end
      if (!last) return;
      in_key = 0;
      f1 = finalize(acc_one);
      f2 = finalize(acc_two);
      m = {47'd0, filter_bits};
      if (m < 64'd64) m = 64'd64;
      if (m > 64'd65536) m = 64'd65536;
      present = 1;
      for (int i = 0; i < int'(hash_count); i++) begin
        idx = 64'(i);
        pos = (f1 + idx * f2) % m;
        if (req == REQ_INSERT) begin
          store[(pos >> 6) % STORE_WORDS][pos[5:0]] = 1'b1;
        end else if (!store[(pos >> 6) % STORE_WORDS][pos[5:0]]) begin
          present = 0;
          break;
        end
      end
      pending.push_back('{req, (req == REQ_QUERY) && present});
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check(logic [1:0] op, logic present);
      bloom_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result op=%0d present=%0d", op, present));
        return;
      end
      want = pending.pop_front();
      if (op !== want.op)
        report($sformatf("completed_op got %0d want %0d", op, want.op));
      if (present !== want.present)
        report($sformatf("maybe_present got %0d want %0d (op %0d)", present,
                         want.present, want.op));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // key_word[63:0], key_len[79:64]
  logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [7:0]  m_axis_tdata;        // maybe_present[0], zeros above
  logic [1:0]  m_axis_tuser;        // completed_op[1:0]
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bloom_filter_double_hash dut (.*);

  bloom_scoreboard sb = new();
  int burst_left = 0;
  int items_sent = 0;
  int hold_go = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_period = 1, stall_duty = 1, stall_phase = 0, stall_cnt = 0;
  logic [31:0] inserted_tags [$];
  logic [15:0] inserted_lens [$];

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  initial begin
    #(12 * 4000000);
    $display("Regression FAIL");
    $finish;
  end

  // receiver: stall pattern plus a long hold-off whenever hold_go is bumped
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check(m_axis_tuser, m_axis_tdata[0]);
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = 3000;
    end
    if (stall_cnt == 0) begin
      stall_cnt = $urandom_range(50, 300);
      stall_period = $urandom_range(1, 8);
      stall_duty = ($urandom_range(0, 3) == 0) ? stall_period :
                   $urandom_range(1, stall_period);
    end
    stall_cnt--;
    stall_phase = (stall_phase + 1) % stall_period;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (stall_phase < stall_duty);
    end
  end

  task automatic send(logic [1:0] req, logic [63:0] word, logic [15:0] len, bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, word};
    s_axis_tuser  <= req;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note(req, word, len, last);
    items_sent++;
  endtask

  function automatic logic [63:0] word_of(logic [31:0] tag, int j);
    return {tag ^ (32'(j) * 32'h85ebca6b), (32'(j) * 32'h9e3779b9) ^ ~tag};
  endfunction

  // early words may carry another request type; only the last one counts
  task automatic send_key(logic [1:0] req, logic [31:0] tag, logic [15:0] len, int words);
    logic [1:0] early;
    for (int j = 0; j < words; j++) begin
      early = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 1)) : req;
      send((j == words - 1) ? req : early, word_of(tag, j), len, j == words - 1);
    end
  endtask

  function automatic int words_for(logic [15:0] len);
    return (len == 0) ? 1 : (int'(len) + 7) / 8;
  endfunction

  task automatic insert_key(logic [31:0] tag, logic [15:0] len);
    send_key(REQ_INSERT, tag, len, words_for(len));
    inserted_tags.push_back(tag);
    inserted_lens.push_back(len);
  endtask

  task automatic clear_filter();
    send(REQ_CLEAR, {$urandom, $urandom}, 16'($urandom), 1'($urandom));
    inserted_tags.delete();
    inserted_lens.delete();
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_FILTER_BITS) sb.filter_bits = data[16:0];
    else sb.hash_count = data[7:0];
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (IDLE_PAUSE) @(posedge clk_i);
  endtask

  task automatic random_traffic(int target, int max_len);
    int r, pick;
    logic [15:0] len;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      len = 16'($urandom_range(0, max_len));
      if (r < 5) begin
        clear_filter();
      end else if (r < 8) begin
        send(REQ_UNUSED, {$urandom, $urandom}, 16'($urandom), 1'($urandom));
      end else if (r < 11) begin
        send_key(REQ_INSERT, $urandom, 16'($urandom), $urandom_range(1, 3));
      end else if (r < 13) begin
        send(2'($urandom_range(0, 1)), {$urandom, $urandom}, 16'($urandom), 1'b0);
        clear_filter();
      end else if (r < 45) begin
        insert_key($urandom, len);
      end else if (inserted_tags.size() > 0 && $urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, inserted_tags.size() - 1);
        send_key(REQ_QUERY, inserted_tags[pick], inserted_lens[pick],
                 words_for(inserted_lens[pick]));
      end else begin
        send_key(REQ_QUERY, $urandom, len, words_for(len));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    insert_key(32'h0, 16'd0);
    send_key(REQ_QUERY, 32'h0, 16'd0, 1);
    send(REQ_INSERT, 64'hffff_ffff_ffff_ffff, 16'd8, 1'b1);
    send(REQ_QUERY, 64'hffff_ffff_ffff_ffff, 16'd8, 1'b1);
    send(REQ_QUERY, 64'h0, 16'd8, 1'b1);
    insert_key(32'hdead_beef, 16'd3);
    send_key(REQ_QUERY, 32'hdead_beef, 16'd3, 1);
    insert_key(32'h1234_5678, 16'd21);
    send_key(REQ_QUERY, 32'h1234_5678, 16'd21, 3);
    send(REQ_INSERT, 64'hffff_ffff_ffff_ffff, 16'hffff, 1'b1);
    send(REQ_QUERY, 64'h0, 16'hffff, 1'b0);
    send(REQ_INSERT, 64'h8000_0000_0000_0001, 16'hffff, 1'b1);
    send(REQ_UNUSED, 64'hffff_ffff_ffff_ffff, 16'hffff, 1'b1);
    send(REQ_QUERY, 64'h1, 16'd16, 1'b0);
    send(REQ_INSERT, 64'h2, 16'd16, 1'b1);
    send(REQ_INSERT, 64'h5, 16'd24, 1'b0);
    clear_filter();
    send_key(REQ_QUERY, 32'hdead_beef, 16'd3, 1);
    drain();

    apb_write(ADDR_HASH_COUNT, 32'd0);
    insert_key($urandom, 16'd5);
    send_key(REQ_QUERY, $urandom, 16'd12, 2);
    drain();

    // long receiver hold-off while requests keep coming
    apb_write(ADDR_HASH_COUNT, 32'd1);
    apb_write(ADDR_FILTER_BITS, 32'd64);
    hold_go++;
    random_traffic(items_sent + 150, 24);
    drain();

    apb_write(ADDR_HASH_COUNT, 32'd3);
    apb_write(ADDR_FILTER_BITS, 32'd100);
    random_traffic(items_sent + 150, 40);
    drain();

    apb_write(ADDR_FILTER_BITS, 32'd0);
    apb_write(ADDR_HASH_COUNT, 32'd7);
    random_traffic(items_sent + 120, 24);
    drain();

    apb_write(ADDR_FILTER_BITS, 32'h1ffff);
    apb_write(ADDR_HASH_COUNT, 32'($urandom_range(2, 12)));
    random_traffic(items_sent + 160, 48);
    drain();

    apb_write(ADDR_FILTER_BITS, 32'd64);
    apb_write(ADDR_HASH_COUNT, 32'd255);
    for (int i = 0; i < 4; i++) insert_key($urandom, 16'($urandom_range(0, 10)));
    for (int i = 0; i < 4; i++)
      send_key(REQ_QUERY, inserted_tags[i], inserted_lens[i], words_for(inserted_lens[i]));
    send_key(REQ_QUERY, $urandom, 16'd4, 1);
    drain();

    apb_write(ADDR_FILTER_BITS, 32'd65536);
    apb_write(ADDR_HASH_COUNT, 32'($urandom_range(1, 8)));
    random_traffic(items_sent + 260, 64);
    drain();

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/bfdh_pkg.sv
rtl/bfdh_mul64.sv
rtl/bfdh_mod.sv
rtl/bfdh_hash.sv
rtl/bloom_filter_double_hash.sv
tb/tb.sv
